/* sv/inm_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the impulse noise membership block.
package inm_pkg;

  localparam int CMD_W      = 2;
  localparam int ROW_W      = 7;
  localparam int COL_W      = 7;
  localparam int PIX_W      = 8;
  localparam int DEV_W      = 16;
  localparam int MEMB_W     = 17;
  localparam int FRAC_Q16   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int RADIUS_W   = 2;

  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  localparam logic [CFG_DATA_W-1:0] ROWS_RESET   = 8'd128;
  localparam logic [CFG_DATA_W-1:0] COLS_RESET   = 8'd128;
  localparam logic [RADIUS_W-1:0]   RADIUS_RESET = 2'd1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [MEMB_W-1:0] MEMB_ONE = 17'h10000;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_MEMB,
    ST_P1_CRD,
    ST_P1_CTR,
    ST_P1_RD,
    ST_P1_ACC,
    ST_P1_DIVLD,
    ST_P1_DIV,
    ST_P1_WR,
    ST_P2_CRD,
    ST_P2_CTR,
    ST_P2_RD,
    ST_P2_ACC,
    ST_P2_MUL,
    ST_P2_DIST,
    ST_P2_CMP,
    ST_P2_DEC,
    ST_P2_DIV,
    ST_P2_WR,
    ST_DONE
  } state_t;

endpackage

/* sv/inm_req_if.sv */
`timescale 1ns / 1ps
// Command channel carrying one input word per handshake.
interface inm_req_if;
  import inm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [PIX_W-1:0]  pixel;
  modport source(output valid, cmd, row, col, pixel, input ready);
  modport sink(input valid, cmd, row, col, pixel, output ready);
endinterface

/* sv/inm_rsp_if.sv */
`timescale 1ns / 1ps
// Result channel carrying one result word per handshake.
interface inm_rsp_if;
  import inm_pkg::*;
  logic              valid;
  logic              ready;
  logic [MEMB_W-1:0] membership;
  logic              kind;
  modport source(output valid, membership, kind, input ready);
  modport sink(input valid, membership, kind, output ready);
endinterface

/* sv/inm_cfg_if.sv */
`timescale 1ns / 1ps
// Configuration write channel with register index and write data.
interface inm_cfg_if;
  import inm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* sv/inm_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module inm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/impulse_noise_membership.sv */
`timescale 1ns / 1ps
// Impulse noise membership block: image store, two window passes and readout.
// A pixel write is stored on acceptance; a read registers the stored word, then presents it.
// A run visits every pixel in a first pass, which stores deviations, and a second pass,
// which stores memberships, both using the shared restoring divider, skipped when no
// division is needed; no word is taken while a result waits.
// Synchronous reset sets rows and cols to 128 and radius to 1; the stores are not cleared.
module impulse_noise_membership #(
  parameter int MAX_ROWS   = 128,
  parameter int MAX_COLS   = 128,
  parameter int MAX_RADIUS = 3
) (
  input logic       clk,
  input logic       rst,
  inm_req_if.sink   req,
  inm_rsp_if.source rsp,
  inm_cfg_if.sink   cfg
);
  import inm_pkg::*;

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RDW   = $clog2(MAX_RADIUS + 1);
  localparam int CNW   = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int SW    = CNW + PIX_W;
  localparam int DW    = CNW + DEV_W;
  localparam int NUMW  = DW + FRAC_Q16;
  localparam int SCW   = $clog2(NUMW + 1);
  localparam int XW    = DW + 3;

  state_t state, state_next;

  logic [CFG_DATA_W-1:0] rows, cols;
  logic [RADIUS_W-1:0]   radius;
  logic [RW:0]           nr;
  logic [CW:0]           nc;
  logic [RDW-1:0]        w;
  logic [RW-1:0]         nrm1;
  logic [CW-1:0]         ncm1;

  logic [RW-1:0] i, k, hi_i;
  logic [CW-1:0] j, l, lo_j, hi_j;
  logic [RW-1:0] lo_i_c, hi_i_c;
  logic [CW-1:0] lo_j_c, hi_j_c;
  logic [RW:0]   i_ext;
  logic [CW:0]   j_ext;

  logic [AW-1:0] addr_ij, addr_kl, in_addr;
  logic          in_inside, accept, win_last, pix_last;

  logic [PIX_W-1:0]  center_pix, pix_diff;
  logic [SW-1:0]     sum1;
  logic [CNW-1:0]    cnt;
  logic [DEV_W-1:0]  center_dev, mn;
  logic [DW-1:0]     sum2, dc, mc, spread, ramp_base;
  logic              gt_flag, ge_flag;
  logic [XW-1:0]     five_dist, six_mc;
  logic [NUMW-1:0]   div_num;
  logic [DW-1:0]     div_rem, div_den;
  logic [MEMB_W-1:0] div_quo;
  logic [SCW-1:0]    div_step;
  logic [DW:0]       rem_sh;
  logic              rem_ge;
  logic              read_inside;

  logic              out_valid, out_kind;
  logic [MEMB_W-1:0] out_memb;

  logic               img_we;
  logic [AW-1:0]      img_raddr, dev_raddr;
  logic [PIX_W-1:0]   img_rdata;
  logic [DEV_W-1:0]   dev_rdata;
  logic [MEMB_W-1:0]  memb_rdata;

  assign nr   = (32'(rows) > MAX_ROWS) ? (RW + 1)'(MAX_ROWS) : (RW + 1)'(rows);
  assign nc   = (32'(cols) > MAX_COLS) ? (CW + 1)'(MAX_COLS) : (CW + 1)'(cols);
  assign w    = (32'(radius) > MAX_RADIUS) ? RDW'(MAX_RADIUS) : RDW'(radius);
  assign nrm1 = RW'(nr - (RW + 1)'(1));
  assign ncm1 = CW'(nc - (CW + 1)'(1));

  assign i_ext  = (RW + 1)'(i) + (RW + 1)'(w);
  assign j_ext  = (CW + 1)'(j) + (CW + 1)'(w);
  assign lo_i_c = (i >= RW'(w)) ? i - RW'(w) : '0;
  assign lo_j_c = (j >= CW'(w)) ? j - CW'(w) : '0;
  assign hi_i_c = (i_ext > (RW + 1)'(nrm1)) ? nrm1 : RW'(i_ext);
  assign hi_j_c = (j_ext > (CW + 1)'(ncm1)) ? ncm1 : CW'(j_ext);

  assign addr_ij   = AW'(i) * AW'(MAX_COLS) + AW'(j);
  assign addr_kl   = AW'(k) * AW'(MAX_COLS) + AW'(l);
  assign in_inside = (32'(req.row) < MAX_ROWS) && (32'(req.col) < MAX_COLS);
  assign in_addr   = AW'(req.row) * AW'(MAX_COLS) + AW'(req.col);

  assign accept   = req.valid && req.ready;
  assign win_last = (k == hi_i) && (l == hi_j);
  assign pix_last = (i == nrm1) && (j == ncm1);

  assign pix_diff  = (img_rdata >= center_pix) ? img_rdata - center_pix
                                               : center_pix - img_rdata;
  assign rem_sh    = {div_rem, div_num[NUMW-1]};
  assign rem_ge    = rem_sh >= {1'b0, div_den};
  assign ramp_base = spread - mc;

  assign req.ready      = (state == ST_IDLE) && !out_valid;
  assign cfg.ready      = 1'b1;
  assign rsp.valid      = out_valid;
  assign rsp.membership = out_memb;
  assign rsp.kind       = out_kind;

  assign img_we    = accept && (req.cmd == CMD_WRITE) && in_inside;
  assign img_raddr = (state == ST_P1_CRD) ? addr_ij : addr_kl;
  assign dev_raddr = (state == ST_P2_CRD) ? addr_ij : addr_kl;

  inm_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_img_ram (
    .clk   (clk),
    .we    (img_we),
    .waddr (in_addr),
    .wdata (req.pixel),
    .raddr (img_raddr),
    .rdata (img_rdata)
  );

  inm_ram #(.WIDTH(DEV_W), .DEPTH(DEPTH)) u_dev_ram (
    .clk   (clk),
    .we    (state == ST_P1_WR),
    .waddr (addr_ij),
    .wdata (div_quo[DEV_W-1:0]),
    .raddr (dev_raddr),
    .rdata (dev_rdata)
  );

  inm_ram #(.WIDTH(MEMB_W), .DEPTH(DEPTH)) u_memb_ram (
    .clk   (clk),
    .we    (state == ST_P2_WR),
    .waddr (addr_ij),
    .wdata (div_quo),
    .raddr (in_addr),
    .rdata (memb_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rows   <= ROWS_RESET;
      cols   <= COLS_RESET;
      radius <= RADIUS_RESET;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_ROWS:   rows   <= cfg.data;
          REG_COLS:   cols   <= cfg.data;
          REG_RADIUS: radius <= cfg.data[RADIUS_W-1:0];
          default:    ;
        endcase
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (req.cmd)
            CMD_RUN:  state_next = (nr == '0 || nc == '0) ? ST_DONE : ST_P1_CRD;
            CMD_READ: state_next = ST_RD_MEMB;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_RD_MEMB:  state_next = ST_IDLE;
      ST_P1_CRD:   state_next = ST_P1_CTR;
      ST_P1_CTR:   state_next = ST_P1_RD;
      ST_P1_RD:    state_next = ST_P1_ACC;
      ST_P1_ACC:   state_next = win_last ? ST_P1_DIVLD : ST_P1_RD;
      ST_P1_DIVLD: state_next = (cnt == '0) ? ST_P1_WR : ST_P1_DIV;
      ST_P1_DIV:   state_next = (div_step == SCW'(NUMW - 1)) ? ST_P1_WR : ST_P1_DIV;
      ST_P1_WR:    state_next = pix_last ? ST_P2_CRD : ST_P1_CRD;
      ST_P2_CRD:   state_next = ST_P2_CTR;
      ST_P2_CTR:   state_next = ST_P2_RD;
      ST_P2_RD:    state_next = ST_P2_ACC;
      ST_P2_ACC:   state_next = win_last ? ST_P2_MUL : ST_P2_RD;
      ST_P2_MUL:   state_next = ST_P2_DIST;
      ST_P2_DIST:  state_next = ST_P2_CMP;
      ST_P2_CMP:   state_next = ST_P2_DEC;
      ST_P2_DEC: begin
        state_next = (gt_flag && !ge_flag && mc != '0) ? ST_P2_DIV : ST_P2_WR;
      end
      ST_P2_DIV:   state_next = (div_step == SCW'(NUMW - 1)) ? ST_P2_WR : ST_P2_DIV;
      ST_P2_WR:    state_next = pix_last ? ST_DONE : ST_P2_CRD;
      ST_DONE:     state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RD_MEMB || state == ST_DONE) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        read_inside <= in_inside;
        i <= '0;
        j <= '0;
      end
      ST_RD_MEMB: begin
        out_memb <= read_inside ? memb_rdata : '0;
        out_kind <= KIND_READ;
      end
      ST_DONE: begin
        out_memb <= '0;
        out_kind <= KIND_DONE;
      end
      ST_P1_CTR: begin
        center_pix <= img_rdata;
        sum1 <= '0;
        cnt  <= '0;
        k    <= lo_i_c;
        l    <= lo_j_c;
        hi_i <= hi_i_c;
        lo_j <= lo_j_c;
        hi_j <= hi_j_c;
      end
      ST_P2_CTR: begin
        center_dev <= dev_rdata;
        mn   <= dev_rdata;
        sum2 <= '0;
        cnt  <= '0;
        k    <= lo_i_c;
        l    <= lo_j_c;
        hi_i <= hi_i_c;
        lo_j <= lo_j_c;
        hi_j <= hi_j_c;
      end
      ST_P1_ACC, ST_P2_ACC: begin
        if (state == ST_P1_ACC) begin
          if (!(k == i && l == j)) begin
            sum1 <= sum1 + SW'(pix_diff);
            cnt  <= cnt + CNW'(1);
          end
        end else begin
          if (dev_rdata < mn) begin
            mn <= dev_rdata;
          end
          sum2 <= sum2 + DW'(dev_rdata);
          cnt  <= cnt + CNW'(1);
        end
        if (l == hi_j) begin
          l <= lo_j;
          k <= k + RW'(1);
        end else begin
          l <= l + CW'(1);
        end
      end
      ST_P1_DIVLD: begin
        div_num  <= NUMW'({sum1, 8'd0}) + NUMW'(cnt >> 1);
        div_den  <= DW'(cnt);
        div_rem  <= '0;
        div_quo  <= '0;
        div_step <= '0;
      end
      ST_P1_DIV, ST_P2_DIV: begin
        div_rem  <= rem_ge ? DW'(rem_sh - {1'b0, div_den}) : rem_sh[DW-1:0];
        div_num  <= div_num << 1;
        div_quo  <= {div_quo[MEMB_W-2:0], rem_ge};
        div_step <= div_step + SCW'(1);
      end
      ST_P1_WR, ST_P2_WR: begin
        if (j == ncm1) begin
          j <= '0;
          i <= pix_last ? '0 : i + RW'(1);
        end else begin
          j <= j + CW'(1);
        end
      end
      ST_P2_MUL: begin
        dc <= DW'(center_dev) * DW'(cnt);
        mc <= DW'(mn) * DW'(cnt);
      end
      ST_P2_DIST: begin
        spread <= (dc >= sum2) ? dc - sum2 : sum2 - dc;
      end
      ST_P2_CMP: begin
        gt_flag <= spread > mc;
        ge_flag <= five_dist >= six_mc;
      end
      ST_P2_DEC: begin
        div_num  <= ((NUMW'(ramp_base) << 2) + NUMW'(ramp_base)) << FRAC_Q16;
        div_den  <= mc;
        div_rem  <= '0;
        div_step <= '0;
        div_quo  <= ge_flag ? MEMB_ONE : '0;
      end
      default: ;
    endcase
  end

  assign five_dist = (XW'(spread) << 2) + XW'(spread);
  assign six_mc    = (XW'(mc) << 2) + (XW'(mc) << 1);

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for the impulse noise membership block: directed and random words.
module testbench;
  import inm_pkg::*;

  localparam int STORE_ROWS = 128;
  localparam int STORE_COLS = 128;
  localparam int DEPTH      = STORE_ROWS * STORE_COLS;
  localparam int TOP_RADIUS = 3;
  localparam int WATCHDOG   = 2000000;
  localparam int WORD_GOAL  = 500;

  typedef struct packed {
    logic [MEMB_W-1:0] membership;
    logic              kind;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  inm_req_if req();
  inm_rsp_if rsp();
  inm_cfg_if cfg();

  impulse_noise_membership DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [PIX_W-1:0]  image_mem [DEPTH];
  logic [DEV_W-1:0]  deviation_mem [DEPTH];
  logic [MEMB_W-1:0] degree_mem [DEPTH];
  bit                degree_known [DEPTH];
  int unsigned       rows_set, cols_set, radius_set;

  reading_t pending_words[$];
  int       error_count = 0;
  int       words_sent = 0;
  int       quiet_cycles = 0;
  bit       calm_source = 1'b0;
  bit       calm_sink = 1'b0;
  int       sink_hold = 0;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic int edge_low(int i, int w);
    return (i >= w) ? i - w : 0;
  endfunction

  function automatic int edge_high(int i, int w, int n);
    return (i + w > n - 1) ? n - 1 : i + w;
  endfunction

  // Both window passes, computed exactly with wide integers.
  task automatic detect_noise();
    int nr, nc, w;
    longint sum, cnt, c, v, d, m, s, dc, spread, mc, res;
    nr = (rows_set > STORE_ROWS) ? STORE_ROWS : rows_set;
    nc = (cols_set > STORE_COLS) ? STORE_COLS : cols_set;
    w  = (radius_set > TOP_RADIUS) ? TOP_RADIUS : radius_set;
    if (nr == 0 || nc == 0) return;
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        c = longint'(image_mem[i * STORE_COLS + j]);
        sum = 0;
        cnt = 0;
        for (int k = edge_low(i, w); k <= edge_high(i, w, nr); k++) begin
          for (int l = edge_low(j, w); l <= edge_high(j, w, nc); l++) begin
            if (k == i && l == j) continue;
            v = longint'(image_mem[k * STORE_COLS + l]);
            sum += (v >= c) ? v - c : c - v;
            cnt++;
          end
        end
        deviation_mem[i * STORE_COLS + j] =
          DEV_W'((cnt != 0) ? (sum * 256 + cnt / 2) / cnt : 0);
      end
    end
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        d = longint'(deviation_mem[i * STORE_COLS + j]);
        m = d;
        s = 0;
        cnt = 0;
        for (int k = edge_low(i, w); k <= edge_high(i, w, nr); k++) begin
          for (int l = edge_low(j, w); l <= edge_high(j, w, nc); l++) begin
            v = longint'(deviation_mem[k * STORE_COLS + l]);
            if (v < m) m = v;
            s += v;
            cnt++;
          end
        end
        dc = d * cnt;
        spread = (dc >= s) ? dc - s : s - dc;
        mc = m * cnt;
        if (spread > mc && 5 * spread < 6 * mc && mc != 0)
          res = (5 * 65536 * (spread - mc)) / mc;
        else if (5 * spread >= 6 * mc) res = 65536;
        else res = 0;
        degree_mem[i * STORE_COLS + j] = MEMB_W'(res);
        degree_known[i * STORE_COLS + j] = 1'b1;
      end
    end
  endtask

  task automatic predict_word(input logic [CMD_W-1:0] op, input int r, input int c,
                              input logic [PIX_W-1:0] px);
    reading_t word;
    if (op == CMD_WRITE) begin
      image_mem[r * STORE_COLS + c] = px;
    end else if (op == CMD_RUN) begin
      detect_noise();
      word.membership = '0;
      word.kind = KIND_DONE;
      pending_words.push_back(word);
    end else if (op == CMD_READ) begin
      word.membership = degree_mem[r * STORE_COLS + c];
      word.kind = KIND_READ;
      pending_words.push_back(word);
    end
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_source || roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Called and returning at a falling edge; valid is low on return.
  task automatic send_word(input logic [CMD_W-1:0] op, input int r, input int c,
                           input logic [PIX_W-1:0] px);
    int gap;
    gap = pick_gap();
    req.valid = 1'b0;
    repeat (gap) @(negedge clk);
    req.cmd = op;
    req.row = ROW_W'(r);
    req.col = COL_W'(c);
    req.pixel = px;
    req.valid = 1'b1;
    do @(posedge clk); while (!req.ready);
    predict_word(op, r, c, px);
    if (op != CMD_NONE) words_sent++;
    @(negedge clk);
    req.valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg.index = idx;
    cfg.data = CFG_DATA_W'(value);
    cfg.valid = 1'b1;
    do @(posedge clk); while (!cfg.ready);
    if (idx == REG_ROWS) rows_set = value & 8'hFF;
    else if (idx == REG_COLS) cols_set = value & 8'hFF;
    else if (idx == REG_RADIUS) radius_set = value & 2'h3;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic set_shape(input int nr, input int nc, input int w);
    drain();
    write_register(REG_ROWS, nr);
    write_register(REG_COLS, nc);
    write_register(REG_RADIUS, w);
  endtask

  // Fills the image in use: smooth, flat, or random, with sparse impulses.
  task automatic fill_image(input int style);
    int nr, nc, base;
    logic [PIX_W-1:0] px;
    nr = (rows_set > STORE_ROWS) ? STORE_ROWS : rows_set;
    nc = (cols_set > STORE_COLS) ? STORE_COLS : cols_set;
    base = $urandom_range(0, 255);
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        case (style)
          0: px = PIX_W'(base);
          1: px = PIX_W'(base + i * 3 + j * 2 + $urandom_range(0, 4));
          default: px = PIX_W'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 9) == 0) px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        send_word(CMD_WRITE, i, j, px);
      end
    end
  endtask

  task automatic read_some(input int count);
    int nr, nc, r, c;
    nr = (rows_set > STORE_ROWS) ? STORE_ROWS : rows_set;
    nc = (cols_set > STORE_COLS) ? STORE_COLS : cols_set;
    for (int n = 0; n < count; n++) begin
      do begin
        r = $urandom_range(0, STORE_ROWS - 1);
        c = $urandom_range(0, STORE_COLS - 1);
        if (nr > 0 && nc > 0 && $urandom_range(0, 3) != 0) begin
          r = $urandom_range(0, nr - 1);
          c = $urandom_range(0, nc - 1);
        end
      end while (!degree_known[r * STORE_COLS + c]);
      send_word(CMD_READ, r, c, PIX_W'($urandom_range(0, 255)));
      if ($urandom_range(0, 7) == 0) begin
        send_word(CMD_WRITE, $urandom_range(0, 127), $urandom_range(0, 127),
                  PIX_W'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 15) == 0) send_word(CMD_NONE, $urandom_range(0, 127),
                                                $urandom_range(0, 127),
                                                PIX_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_tiny_images();
    set_shape(1, 1, 1);
    send_word(CMD_WRITE, 0, 0, 8'hA5);
    send_word(CMD_RUN, 0, 0, 8'h00);
    send_word(CMD_READ, 0, 0, 8'h00);
    set_shape(2, 3, 3);
    fill_image(2);
    send_word(CMD_RUN, 0, 0, 8'h00);
    read_some(3);
    set_shape(0, 9, 2);
    send_word(CMD_RUN, 0, 0, 8'h00);
    set_shape(8, 8, 0);
    fill_image(2);
    send_word(CMD_RUN, 0, 0, 8'h00);
    read_some(3);
    send_word(CMD_NONE, 127, 127, 8'hFF);
  endtask

  task automatic test_flat_image();
    set_shape(8, 8, 1);
    fill_image(0);
    send_word(CMD_RUN, 0, 0, 8'h00);
    read_some(3);
  endtask

  task automatic test_narrow_shapes();
    set_shape(16, 8, 1);
    fill_image(1);
    send_word(CMD_RUN, 0, 0, 8'h00);
    send_word(CMD_READ, 15, 7, 8'h00);
    send_word(CMD_READ, 0, 0, 8'h00);
    set_shape(8, 16, 3);
    fill_image(2);
    send_word(CMD_RUN, 0, 0, 8'h00);
    send_word(CMD_READ, 7, 15, 8'h00);
    send_word(CMD_READ, 0, 8, 8'h00);
  endtask

  task automatic test_random_images();
    while (words_sent < WORD_GOAL) begin
      calm_source = ($urandom_range(0, 3) == 0);
      calm_sink = ($urandom_range(0, 3) == 0);
      set_shape($urandom_range(8, 12), $urandom_range(8, 12),
                ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3));
      for (int n = 0; n < 4; n++) begin
        send_word(CMD_WRITE, $urandom_range(0, 127), $urandom_range(0, 127),
                  PIX_W'($urandom_range(0, 255)));
      end
      fill_image($urandom_range(0, 5) == 0 ? 0 : $urandom_range(1, 2));
      send_word(CMD_RUN, $urandom_range(0, 127), $urandom_range(0, 127),
                PIX_W'($urandom_range(0, 255)));
      read_some($urandom_range(15, 35));
    end
  endtask

  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if (calm_sink) begin
      rsp.ready <= 1'b1;
    end else begin
      rsp.ready <= ($urandom_range(0, 3) != 0);
      sink_hold <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : 0;
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word membership %0d kind %0d", rsp.membership,
                         rsp.kind));
      end else begin
        want = pending_words.pop_front();
        if (rsp.membership !== want.membership)
          report($sformatf("membership %0d, wanted %0d", rsp.membership, want.membership));
        if (rsp.kind !== want.kind)
          report($sformatf("kind %0d, wanted %0d", rsp.kind, want.kind));
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("[impulse_noise_membership] ERROR");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.cmd = CMD_WRITE;
    req.row = '0;
    req.col = '0;
    req.pixel = '0;
    cfg.valid = 1'b0;
    cfg.index = REG_ROWS;
    cfg.data = '0;
    rsp.ready = 1'b0;
    rows_set = ROWS_RESET;
    cols_set = COLS_RESET;
    radius_set = RADIUS_RESET;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_tiny_images();
    test_flat_image();
    test_narrow_shapes();
    test_random_images();
    drain();
    if (error_count == 0) begin
      $display("[impulse_noise_membership] OK");
    end else begin
      $display("[impulse_noise_membership] ERROR");
    end
    $finish;
  end

endmodule
